/* design/ssg_pkg.sv */
// Shared types and constants for the seven-segment scan and tap gate.
`timescale 1ns / 1ps
package ssg_pkg;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_TAP  = 2'd1;
    localparam logic [1:0] CMD_WAKE = 2'd2;

    localparam logic [2:0] CFG_ANODE_POLARITY = 3'd0;
    localparam logic [2:0] CFG_TICK_RELOAD    = 3'd1;
    localparam logic [2:0] CFG_AGE_LIMIT      = 3'd2;
    localparam logic [2:0] CFG_TAP_HOLDOFF    = 3'd3;
    localparam logic [2:0] CFG_QUEUE_LIMIT    = 3'd4;

    localparam logic       RST_ANODE_POLARITY = 1'b0;
    localparam logic [7:0] RST_TICK_RELOAD    = 8'd65;
    localparam logic [7:0] RST_AGE_LIMIT      = 8'd200;
    localparam logic [7:0] RST_TAP_HOLDOFF    = 8'd12;
    localparam logic [2:0] RST_QUEUE_LIMIT    = 3'd2;

    localparam logic [2:0] PHASE_RELOAD = 3'b100;
    localparam int         DP_BIT       = 7;

    typedef struct packed {
        logic       anode_polarity;
        logic [7:0] tick_reload;
        logic [7:0] age_limit;
        logic [7:0] tap_holdoff;
        logic [2:0] queue_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] segments_first;
        logic [7:0] segments_second;
        logic [7:0] brightness_first;
        logic [7:0] brightness_second;
        logic [2:0] queue_used;
    } item_t;

    typedef struct packed {
        logic [7:0] seg_port;
        logic       dp_line;
        logic       first_enable;
        logic       second_enable;
        logic [7:0] pwm_first;
        logic [7:0] pwm_second;
        logic       scheduler_tick;
        logic       tap_posted;
        logic [7:0] tap_age;
        logic [7:0] random_value;
        logic       scan_updated;
    } result_t;

endpackage

/* design/seven_segment_scan_and_tap_gate.sv */
// Top level: config registers, request register, core and result register.
`timescale 1ns / 1ps
// Takes one request per clock unless stalled (tick, tap or wake in s_tuser) and
// returns one result per request: the request lands in an input register at the
// accepting edge, the core updates its counters and scan state in one pass, and
// m_tvalid rises as the result register loads and holds the answer until
// m_tready takes it. A stalled result blocks only when the request register is
// also full. Config writes take effect at once and belong to idle periods.
module seven_segment_scan_and_tap_gate (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // segments_first, segments_second, brightness_first, brightness_second,
    // queue_used
    input  logic [39:0] s_tdata,
    // cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // seg_port, dp_line, first_enable, second_enable, pwm_first, pwm_second,
    // scheduler_tick, tap_posted, tap_age, random_value, scan_updated
    output logic [47:0] m_tdata
);
    import ssg_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t res;
    logic    advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.anode_polarity <= RST_ANODE_POLARITY;
            cfg_reg.tick_reload    <= RST_TICK_RELOAD;
            cfg_reg.age_limit      <= RST_AGE_LIMIT;
            cfg_reg.tap_holdoff    <= RST_TAP_HOLDOFF;
            cfg_reg.queue_limit    <= RST_QUEUE_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ANODE_POLARITY: cfg_reg.anode_polarity <= cfg_wdata[0];
                CFG_TICK_RELOAD:    cfg_reg.tick_reload    <= cfg_wdata;
                CFG_AGE_LIMIT:      cfg_reg.age_limit      <= cfg_wdata;
                CFG_TAP_HOLDOFF:    cfg_reg.tap_holdoff    <= cfg_wdata;
                CFG_QUEUE_LIMIT:    cfg_reg.queue_limit    <= cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.cmd               <= s_tuser;
            in_item_reg.segments_first    <= s_tdata[7:0];
            in_item_reg.segments_second   <= s_tdata[15:8];
            in_item_reg.brightness_first  <= s_tdata[23:16];
            in_item_reg.brightness_second <= s_tdata[31:24];
            in_item_reg.queue_used        <= s_tdata[34:32];
        end
    end

    ssg_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.scan_updated,
                       out_res_reg.random_value,
                       out_res_reg.tap_age,
                       out_res_reg.tap_posted,
                       out_res_reg.scheduler_tick,
                       out_res_reg.pwm_second,
                       out_res_reg.pwm_first,
                       out_res_reg.second_enable,
                       out_res_reg.first_enable,
                       out_res_reg.dp_line,
                       out_res_reg.seg_port};

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced request produced no result");

    a_tick_tap_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[27] && m_tdata[28]))
        else $error("scheduler tick and tap post in one result");

    a_age_zero_no_post: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[28]) |-> (m_tdata[36:29] == 8'd0))
        else $error("tap age reported without a posted tap");

endmodule

/* design/ssg_core.sv */
// Event state update: counters, divider, age gate and display scan.
`timescale 1ns / 1ps
module ssg_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  ssg_pkg::cfg_t    cfg,
    input  ssg_pkg::item_t   item,
    output ssg_pkg::result_t result
);
    import ssg_pkg::*;

    logic [7:0] free_reg,    free_next;
    logic [7:0] div_reg,     div_next;
    logic [7:0] age_reg,     age_next;
    logic [2:0] phase_reg,   phase_next;
    logic [7:0] mask_reg,    mask_next;
    logic       sel_reg,     sel_next;
    logic [7:0] port_reg,    port_next;
    logic       dp_reg,      dp_next;
    logic       en1_reg,     en1_next;
    logic       en2_reg,     en2_next;
    logic [7:0] pwm1_reg,    pwm1_next;
    logic [7:0] pwm2_reg,    pwm2_next;

    logic       sched;
    logic       posted;
    logic [7:0] tage;
    logic       scanned;
    logic [7:0] shifted;
    logic [7:0] seg;

    always_comb begin
        free_next  = free_reg;
        div_next   = div_reg;
        age_next   = age_reg;
        phase_next = phase_reg;
        mask_next  = mask_reg;
        sel_next   = sel_reg;
        port_next  = port_reg;
        dp_next    = dp_reg;
        en1_next   = en1_reg;
        en2_next   = en2_reg;
        pwm1_next  = pwm1_reg;
        pwm2_next  = pwm2_reg;
        sched      = 1'b0;
        posted     = 1'b0;
        tage       = 8'd0;
        scanned    = 1'b0;
        shifted    = {mask_reg[6:0], 1'b0};
        seg        = 8'd0;

        case (item.cmd)
            CMD_TICK: begin
                free_next = free_reg + 8'd1;
                if (div_reg == 8'd0) begin
                    if (age_reg < cfg.age_limit) begin
                        age_next = age_reg + 8'd1;
                    end
                    sched    = 1'b1;
                    div_next = cfg.tick_reload;
                end else begin
                    div_next = div_reg - 8'd1;
                end
                if (phase_reg != 3'd0) begin
                    phase_next = phase_reg >> 1;
                end else begin
                    phase_next = PHASE_RELOAD;
                    scanned    = 1'b1;
                    // wrap to bit zero and flip display
                    if (shifted == 8'd0) begin
                        sel_next  = ~sel_reg;
                        mask_next = 8'd1;
                    end else begin
                        mask_next = shifted;
                    end
                    seg = sel_next ? item.segments_second : item.segments_first;
                    if (cfg.anode_polarity) begin
                        port_next = seg | ~mask_next;
                        dp_next   = ~seg[DP_BIT];
                    end else begin
                        port_next = seg & mask_next;
                        dp_next   = seg[DP_BIT];
                    end
                    if (!sel_next) begin
                        pwm1_next = item.brightness_first;
                        en1_next  = 1'b1;
                        en2_next  = 1'b0;
                    end else begin
                        pwm2_next = item.brightness_second;
                        en2_next  = 1'b1;
                        en1_next  = 1'b0;
                    end
                end
            end
            CMD_TAP: begin
                if (item.queue_used <= cfg.queue_limit &&
                    (age_reg == 8'd0 || age_reg > cfg.tap_holdoff)) begin
                    posted   = 1'b1;
                    tage     = age_reg;
                    age_next = 8'd1;
                end
            end
            CMD_WAKE: begin
                age_next = 8'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg  <= 8'd0;
            div_reg   <= 8'd0;
            age_reg   <= 8'd0;
            phase_reg <= 3'd0;
            mask_reg  <= 8'd1;
            sel_reg   <= 1'b0;
            port_reg  <= 8'd0;
            dp_reg    <= 1'b0;
            en1_reg   <= 1'b0;
            en2_reg   <= 1'b0;
            pwm1_reg  <= 8'd0;
            pwm2_reg  <= 8'd0;
        end else if (advance) begin
            free_reg  <= free_next;
            div_reg   <= div_next;
            age_reg   <= age_next;
            phase_reg <= phase_next;
            mask_reg  <= mask_next;
            sel_reg   <= sel_next;
            port_reg  <= port_next;
            dp_reg    <= dp_next;
            en1_reg   <= en1_next;
            en2_reg   <= en2_next;
            pwm1_reg  <= pwm1_next;
            pwm2_reg  <= pwm2_next;
        end
    end

    always_comb begin
        result.seg_port       = port_next;
        result.dp_line        = dp_next;
        result.first_enable   = en1_next;
        result.second_enable  = en2_next;
        result.pwm_first      = pwm1_next;
        result.pwm_second     = pwm2_next;
        result.scheduler_tick = sched;
        result.tap_posted     = posted;
        result.tap_age        = tage;
        result.random_value   = free_next;
        result.scan_updated   = scanned;
    end

endmodule

/* test/tb.sv */
// Testbench for seven_segment_scan_and_tap_gate: directed and random requests checked per field.
`timescale 1ns / 1ps
module tb;
    import ssg_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 60;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic [7:0] seg_port;
        logic       dp_line;
        logic       first_enable;
        logic       second_enable;
        logic [7:0] pwm_first;
        logic [7:0] pwm_second;
    } display_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // segments_first, segments_second, brightness_first, brightness_second, queue_used
    logic [39:0] s_tdata = '0;
    // cmd
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // seg_port, dp_line, first_enable, second_enable, pwm_first, pwm_second,
    // scheduler_tick, tap_posted, tap_age, random_value, scan_updated
    logic [47:0] m_tdata;

    cfg_t       cfg_mirror;
    logic [7:0] free_cnt;
    logic [7:0] div_cnt;
    logic [7:0] age_cnt;
    logic [2:0] phase;
    logic [7:0] scan_mask;
    logic       disp_sel;
    display_t   held_display;

    result_t pending_results[$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      tx_idle_pct = 0;
    int      rx_stall_pct = 0;
    int      hold_until = 0;

    seven_segment_scan_and_tap_gate i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (cycle_count < hold_until) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0d want %0d",
                     cycle_count, what, got, want);
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.seg_port       = m_tdata[7:0];
            got.dp_line        = m_tdata[8];
            got.first_enable   = m_tdata[9];
            got.second_enable  = m_tdata[10];
            got.pwm_first      = m_tdata[18:11];
            got.pwm_second     = m_tdata[26:19];
            got.scheduler_tick = m_tdata[27];
            got.tap_posted     = m_tdata[28];
            got.tap_age        = m_tdata[36:29];
            got.random_value   = m_tdata[44:37];
            got.scan_updated   = m_tdata[45];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, seg_port", got.seg_port, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.seg_port !== want.seg_port)
                    report_mismatch("seg_port", got.seg_port, want.seg_port);
                if (got.dp_line !== want.dp_line)
                    report_mismatch("dp_line", got.dp_line, want.dp_line);
                if (got.first_enable !== want.first_enable)
                    report_mismatch("first_enable", got.first_enable, want.first_enable);
                if (got.second_enable !== want.second_enable)
                    report_mismatch("second_enable", got.second_enable, want.second_enable);
                if (got.pwm_first !== want.pwm_first)
                    report_mismatch("pwm_first", got.pwm_first, want.pwm_first);
                if (got.pwm_second !== want.pwm_second)
                    report_mismatch("pwm_second", got.pwm_second, want.pwm_second);
                if (got.scheduler_tick !== want.scheduler_tick)
                    report_mismatch("scheduler_tick", got.scheduler_tick, want.scheduler_tick);
                if (got.tap_posted !== want.tap_posted)
                    report_mismatch("tap_posted", got.tap_posted, want.tap_posted);
                if (got.tap_age !== want.tap_age)
                    report_mismatch("tap_age", got.tap_age, want.tap_age);
                if (got.random_value !== want.random_value)
                    report_mismatch("random_value", got.random_value, want.random_value);
                if (got.scan_updated !== want.scan_updated)
                    report_mismatch("scan_updated", got.scan_updated, want.scan_updated);
            end
        end
    end

    function automatic result_t step_gate(input item_t req);
        result_t    res;
        logic [7:0] seg;
        res = '0;
        case (req.cmd)
            CMD_TICK: begin
                free_cnt = free_cnt + 8'd1;
                if (div_cnt == 8'd0) begin
                    if (age_cnt < cfg_mirror.age_limit)
                        age_cnt = age_cnt + 8'd1;
                    res.scheduler_tick = 1'b1;
                    div_cnt = cfg_mirror.tick_reload;
                end else begin
                    div_cnt = div_cnt - 8'd1;
                end
                if (phase != 3'd0) begin
                    phase = phase >> 1;
                end else begin
                    phase = PHASE_RELOAD;
                    scan_mask = scan_mask << 1;
                    if (scan_mask == 8'd0) begin
                        disp_sel = ~disp_sel;
                        scan_mask = 8'd1;
                    end
                    seg = disp_sel ? req.segments_second : req.segments_first;
                    if (cfg_mirror.anode_polarity) begin
                        held_display.seg_port = seg | ~scan_mask;
                        held_display.dp_line = ~seg[DP_BIT];
                    end else begin
                        held_display.seg_port = seg & scan_mask;
                        held_display.dp_line = seg[DP_BIT];
                    end
                    if (!disp_sel) begin
                        held_display.pwm_first = req.brightness_first;
                        held_display.first_enable = 1'b1;
                        held_display.second_enable = 1'b0;
                    end else begin
                        held_display.pwm_second = req.brightness_second;
                        held_display.second_enable = 1'b1;
                        held_display.first_enable = 1'b0;
                    end
                    res.scan_updated = 1'b1;
                end
            end
            CMD_TAP: begin
                if (req.queue_used <= cfg_mirror.queue_limit &&
                    (age_cnt == 8'd0 || age_cnt > cfg_mirror.tap_holdoff)) begin
                    res.tap_posted = 1'b1;
                    res.tap_age = age_cnt;
                    age_cnt = 8'd1;
                end
            end
            CMD_WAKE: begin
                age_cnt = 8'd0;
            end
            default: begin
            end
        endcase
        res.seg_port      = held_display.seg_port;
        res.dp_line       = held_display.dp_line;
        res.first_enable  = held_display.first_enable;
        res.second_enable = held_display.second_enable;
        res.pwm_first     = held_display.pwm_first;
        res.pwm_second    = held_display.pwm_second;
        res.random_value  = free_cnt;
        return res;
    endfunction

    function automatic item_t make_item(input logic [1:0] cmd, input logic [7:0] seg_a,
                                        input logic [7:0] seg_b, input logic [7:0] bri_a,
                                        input logic [7:0] bri_b, input logic [2:0] qused);
        item_t req;
        req.cmd = cmd;
        req.segments_first = seg_a;
        req.segments_second = seg_b;
        req.brightness_first = bri_a;
        req.brightness_second = bri_b;
        req.queue_used = qused;
        return req;
    endfunction

    function automatic item_t random_item();
        int         pick;
        logic [1:0] cmd;
        pick = $urandom_range(99);
        if (pick < 55)
            cmd = CMD_TICK;
        else if (pick < 80)
            cmd = CMD_TAP;
        else if (pick < 93)
            cmd = CMD_WAKE;
        else
            cmd = CMD_UNUSED;
        return make_item(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         3'($urandom_range(7)));
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.anode_polarity = 1'($urandom_range(1));
        c.tick_reload = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                     : $urandom_range(7));
        c.age_limit = 8'(($urandom_range(3) == 0) ? $urandom_range(255, 1)
                                                   : $urandom_range(40, 1));
        c.tap_holdoff = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                     : $urandom_range(12));
        c.queue_limit = 3'($urandom_range(7));
        return c;
    endfunction

    task automatic send_item(input item_t req);
        result_t want;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req.cmd;
        s_tdata <= {5'd0, req.queue_used, req.brightness_second, req.brightness_first,
                    req.segments_second, req.segments_first};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        want = step_gate(req);
        pending_results.push_back(want);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input cfg_t c);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ANODE_POLARITY;
        cfg_wdata <= {7'd0, c.anode_polarity};
        @(posedge aclk);
        cfg_index <= CFG_TICK_RELOAD;
        cfg_wdata <= c.tick_reload;
        @(posedge aclk);
        cfg_index <= CFG_AGE_LIMIT;
        cfg_wdata <= c.age_limit;
        @(posedge aclk);
        cfg_index <= CFG_TAP_HOLDOFF;
        cfg_wdata <= c.tap_holdoff;
        @(posedge aclk);
        cfg_index <= CFG_QUEUE_LIMIT;
        cfg_wdata <= {5'd0, c.queue_limit};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_mirror = c;
    endtask

    task automatic test_field_extremes();
        send_item(make_item(CMD_TICK, 8'hFF, 8'h00, 8'hFF, 8'h00, 3'd7));
        send_item(make_item(CMD_TICK, 8'h00, 8'hFF, 8'h00, 8'hFF, 3'd0));
        send_item(make_item(CMD_TAP, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0));
        send_item(make_item(CMD_WAKE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7));
        send_item(make_item(CMD_TAP, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7));
        send_item(make_item(CMD_TAP, 8'h00, 8'h00, 8'h00, 8'h00, RST_QUEUE_LIMIT));
        send_item(make_item(CMD_TAP, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0));
        send_item(make_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 3'd5));
    endtask

    task automatic test_age_saturation();
        cfg_t c;
        c.anode_polarity = 1'b1;
        c.tick_reload = 8'd0;
        c.age_limit = 8'd6;
        c.tap_holdoff = 8'd3;
        c.queue_limit = 3'd7;
        set_config(c);
        send_item(make_item(CMD_WAKE, 8'h80, 8'h7F, 8'h11, 8'h22, 3'd0));
        repeat (7) send_item(make_item(CMD_TICK, 8'h80, 8'h7F, 8'h33, 8'h44, 3'd0));
        c.age_limit = 8'd2;
        set_config(c);
        send_item(make_item(CMD_TICK, 8'h55, 8'hAA, 8'h66, 8'h77, 3'd0));
        send_item(make_item(CMD_TAP, 8'h55, 8'hAA, 8'h66, 8'h77, 3'd7));
    endtask

    task automatic test_backpressure();
        wait_idle();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_until = cycle_count + 300;
        repeat (40) send_item(random_item());
    endtask

    task automatic test_random_traffic();
        cfg_t c;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: c = {RST_ANODE_POLARITY, RST_TICK_RELOAD, RST_AGE_LIMIT,
                        RST_TAP_HOLDOFF, RST_QUEUE_LIMIT};
                1: c = {1'b0, 8'd0, 8'd1, 8'd0, 3'd0};
                2: c = {1'b1, 8'd255, 8'd255, 8'd255, 3'd7};
                default: c = random_config();
            endcase
            set_config(c);
            case (p % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 83;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 83;
                end
                default: begin
                    tx_idle_pct = 36;
                    rx_stall_pct = 36;
                end
            endcase
            repeat (185) send_item(random_item());
        end
    endtask

    initial begin
        cfg_mirror = {RST_ANODE_POLARITY, RST_TICK_RELOAD, RST_AGE_LIMIT,
                      RST_TAP_HOLDOFF, RST_QUEUE_LIMIT};
        free_cnt = '0;
        div_cnt = '0;
        age_cnt = '0;
        phase = '0;
        scan_mask = 8'd1;
        disp_sel = 1'b0;
        held_display = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_age_saturation();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
